// ===== rtl/mcmono_pkg.sv =====
// Shared constants and types for the mono downmix unit.
`default_nettype none
package mcmono_pkg;

    localparam int MAX_CHANNELS = 8;

    // Configuration register indexes and field widths.
    localparam int                 CFG_IDX_W    = 1;
    localparam int                 CFG_W        = 4;
    localparam int                 CFG_FMT_W    = 2;
    localparam int                 CFG_CH_W     = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 1'd1;

    // Sample format codes.
    localparam logic [CFG_FMT_W-1:0] FMT_INT16   = 2'd0;
    localparam logic [CFG_FMT_W-1:0] FMT_FLOAT32 = 2'd1;
    localparam logic [CFG_FMT_W-1:0] FMT_RESET   = FMT_FLOAT32;
    localparam logic [CFG_CH_W-1:0]  CH_RESET    = 4'd2;

    // Frame arithmetic widths.
    localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
    localparam int POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SUM_W  = 36;
    localparam int MAG_W  = SUM_W - 1;
    localparam int MUL_W  = 24 + $clog2(MAX_CHANNELS);
    localparam int PROD_W = MUL_W + 15;
    localparam int NUM_W  = MUL_W + 17;
    localparam int DIV_W  = 16 + $clog2(MAX_CHANNELS);
    localparam int CNT_W  = $clog2(DIV_W);

    localparam int FIFO_DEPTH = 2;

    localparam logic [14:0]        PCM_SCALE = 15'd32767;
    localparam logic signed [15:0] PCM_MAX   = 16'sh7FFF;
    localparam logic signed [15:0] PCM_MIN   = 16'sh8000;

    // One completed frame handed from the front end to the back end.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    zero;
        logic                    is_int;
        logic [CH_W-1:0]         ch;
        logic                    pkt_end;
    } t_frame;

endpackage
`default_nettype wire

// ===== rtl/mcmono_front.sv =====
// Front end: configuration, sample conversion and per-frame accumulation.
`default_nettype none
module mcmono_front (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [mcmono_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [mcmono_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire [31:0]                     i_sample_bits,
    input  wire                            i_silent,
    input  wire                            i_packet_last,
    input  wire                            i_fifo_full,
    output logic                           o_push,
    output mcmono_pkg::t_frame             o_frame
);
    import mcmono_pkg::*;

    logic [CFG_FMT_W-1:0]    r_fmt;
    logic [CFG_CH_W-1:0]     r_cc;
    logic signed [SUM_W-1:0] r_sum;
    logic [POS_W-1:0]        r_pos;
    logic                    r_sil;
    logic                    r_pend;

    logic [CH_W-1:0]         ch_act;
    logic signed [SUM_W-1:0] sample_val;
    logic signed [SUM_W-1:0] n_sum;
    logic [31:0]             fmag;
    logic                    accept;
    logic                    last;

    function automatic logic [31:0] flt_mag(input logic [31:0] b);
        logic [7:0]  e;
        logic [31:0] sig;
        logic [31:0] m;
        e   = b[30:23];
        sig = {9'b1, b[22:0]};
        m   = '0;
        if (e == 8'hFF) begin
            m = (b[22:0] != 23'd0) ? 32'd0 : 32'h8000_0000;
        end else if (e == 8'd0) begin
            m = '0;
        end else if (e >= 8'd134) begin
            m = 32'h8000_0000;
        end else if (e >= 8'd126) begin
            m = sig << (e - 8'd126);
        end else if (e > 8'd102) begin
            m = sig >> (8'd126 - e);
        end else begin
            m = '0;
        end
        return m;
    endfunction

    always_comb begin
        if (r_cc == '0) begin
            ch_act = CH_W'(1);
        end else if (int'(r_cc) > MAX_CHANNELS) begin
            ch_act = CH_W'(MAX_CHANNELS);
        end else begin
            ch_act = CH_W'(r_cc);
        end
    end

    assign fmag = flt_mag(i_sample_bits);

    always_comb begin
        case (r_fmt)
            FMT_INT16: begin
                sample_val = {{(SUM_W-16){i_sample_bits[15]}}, i_sample_bits[15:0]};
            end
            FMT_FLOAT32: begin
                sample_val = i_sample_bits[31] ? -SUM_W'(fmag) : SUM_W'(fmag);
            end
            default: begin
                sample_val = '0;
            end
        endcase
    end

    assign n_sum      = r_sum + sample_val;
    assign o_in_ready = !i_fifo_full;
    assign accept     = i_in_valid && o_in_ready;
    assign last       = (r_pos == POS_W'(ch_act - CH_W'(1)));
    assign o_push     = accept && last;

    always_comb begin
        o_frame.sum     = n_sum;
        o_frame.zero    = i_silent || r_sil ||
                          ((r_fmt != FMT_INT16) && (r_fmt != FMT_FLOAT32));
        o_frame.is_int  = (r_fmt == FMT_INT16);
        o_frame.ch      = ch_act;
        o_frame.pkt_end = i_packet_last || r_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= FMT_RESET;
            r_cc   <= CH_RESET;
            r_sum  <= '0;
            r_pos  <= '0;
            r_sil  <= 1'b0;
            r_pend <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_FORMAT) begin
                r_fmt <= i_cfg_data[CFG_FMT_W-1:0];
            end
            if (i_cfg_index == CFG_CHANNELS) begin
                r_cc <= i_cfg_data[CFG_CH_W-1:0];
            end
            r_sum  <= '0;
            r_pos  <= '0;
            r_sil  <= 1'b0;
            r_pend <= 1'b0;
        end else if (accept) begin
            if (last) begin
                r_sum  <= '0;
                r_pos  <= '0;
                r_sil  <= 1'b0;
                r_pend <= 1'b0;
            end else begin
                r_sum  <= n_sum;
                r_pos  <= r_pos + POS_W'(1);
                r_sil  <= r_sil || i_silent;
                r_pend <= r_pend || i_packet_last;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mcmono_fifo.sv =====
// Short frame queue between the front end and the back end.
`default_nettype none
module mcmono_fifo (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  mcmono_pkg::t_frame i_din,
    output logic               o_full,
    input  wire                i_pop,
    output mcmono_pkg::t_frame o_dout,
    output logic               o_empty
);
    import mcmono_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_Q = $clog2(FIFO_DEPTH + 1);

    t_frame             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_Q-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_Q'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_dout  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_Q'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_Q'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mcmono_back.sv =====
// Back end: scaling, rounding division by the channel count and output register.
`default_nettype none
module mcmono_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_empty,
    input  mcmono_pkg::t_frame i_frame,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic signed [15:0] o_mono_sample,
    output logic               o_packet_end
);
    import mcmono_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state                  r_state;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_zero;
    logic                    r_int;
    logic [CH_W-1:0]         r_ch;
    logic                    r_pend;
    logic                    r_neg;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_sat;
    logic [PROD_W-1:0]       r_prod;
    logic [DIV_W-1:0]        r_quo;
    logic [POS_W-1:0]        r_rem;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_out_valid;
    logic signed [15:0]      r_out_sample;
    logic                    r_out_pend;

    logic [NUM_W-1:0]        num;
    logic [POS_W:0]          trial;
    logic                    qbit;
    logic [POS_W:0]          n_rem;
    logic signed [15:0]      result;
    logic                    out_load;

    assign o_pop         = (r_state == ST_IDLE) && !i_empty;
    assign o_out_valid   = r_out_valid;
    assign o_mono_sample = r_out_sample;
    assign o_packet_end  = r_out_pend;
    assign out_load      = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);

    // Rounding numerator: 2 * mag * 32767 plus half of the divisor.
    assign num = NUM_W'({r_prod, 1'b0}) +
                 (r_int ? (NUM_W'(r_ch) << 15) : (NUM_W'(r_ch) << 24));

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign qbit  = (trial >= (POS_W+1)'(r_ch));
    assign n_rem = qbit ? (trial - (POS_W+1)'(r_ch)) : trial;

    always_comb begin
        if (r_zero) begin
            result = '0;
        end else if (r_sat) begin
            result = r_neg ? -PCM_MAX : PCM_MAX;
        end else if (r_quo > DIV_W'(PCM_MAX)) begin
            result = r_neg ? PCM_MIN : PCM_MAX;
        end else begin
            result = r_neg ? -signed'(r_quo[15:0]) : signed'(r_quo[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_sum   <= i_frame.sum;
                        r_zero  <= i_frame.zero;
                        r_int   <= i_frame.is_int;
                        r_ch    <= i_frame.ch;
                        r_pend  <= i_frame.pkt_end;
                        r_state <= ST_ABS;
                    end
                end
                ST_ABS: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_mag   <= r_sum[SUM_W-1] ? MAG_W'(-r_sum) : MAG_W'(r_sum);
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod  <= PROD_W'(r_mag[MUL_W-1:0]) * PROD_W'(PCM_SCALE);
                    r_sat   <= !r_int && (r_mag >= (MAG_W'(r_ch) << 24));
                    r_state <= ST_PREP;
                end
                ST_PREP: begin
                    r_quo   <= r_int ? num[16 +: DIV_W] : num[25 +: DIV_W];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= n_rem[POS_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], qbit};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIV_W - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_load) begin
                        r_out_sample <= result;
                        r_out_pend   <= r_pend;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/multichannel_to_mono_pcm16_unit.sv =====
// Top level of the interleaved-channel to mono PCM16 downmix unit.
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  ---------------------------------------
//  input     i_in_valid / o_in_ready      i_sample_bits, i_silent, i_packet_last
//  output    o_out_valid / i_out_ready    o_mono_sample, o_packet_end
//  config    i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// The front end takes one sample transaction per cycle while the two-entry frame queue has room.
// A frame holds the back end from the pop through three scaling states (ABS, MUL, PREP), the
// one-bit-per-cycle divider and the load of the output register; it pops the next frame only when idle.
// Reset is synchronous; it restores float32 format and two channels and clears the partial frame.
// A stalled output holds the result register and the back end waits, then the queue fills.
`default_nettype none
module multichannel_to_mono_pcm16_unit (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [mcmono_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [mcmono_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire [31:0]                      i_sample_bits,
    input  wire                             i_silent,
    input  wire                             i_packet_last,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic signed [15:0]              o_mono_sample,
    output logic                            o_packet_end
);
    import mcmono_pkg::*;

    t_frame push_frame;
    t_frame pop_frame;
    logic   push;
    logic   pop;
    logic   fifo_full;
    logic   fifo_empty;

    mcmono_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample_bits (i_sample_bits),
        .i_silent      (i_silent),
        .i_packet_last (i_packet_last),
        .i_fifo_full   (fifo_full),
        .o_push        (push),
        .o_frame       (push_frame)
    );

    mcmono_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (push_frame),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_dout  (pop_frame),
        .o_empty (fifo_empty)
    );

    mcmono_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (fifo_empty),
        .i_frame       (pop_frame),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_mono_sample (o_mono_sample),
        .o_packet_end  (o_packet_end)
    );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the multichannel to mono PCM16 downmix unit.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import mcmono_pkg::*;

    localparam logic [CFG_FMT_W-1:0] FMT_SPARE_LO = 2'd2;
    localparam logic [CFG_FMT_W-1:0] FMT_SPARE_HI = 2'd3;

    localparam logic [31:0] FP_POS_INF   = 32'h7F80_0000;
    localparam logic [31:0] FP_NEG_INF   = 32'hFF80_0000;
    localparam logic [31:0] FP_NAN       = 32'h7FC0_0001;
    localparam logic [31:0] FP_SUBNORMAL = 32'h0000_0001;
    localparam logic [31:0] FP_TINY      = 32'h3300_0000;
    localparam logic [31:0] FP_ONE_HALF  = 32'h3F00_0000;
    localparam logic [31:0] FP_ONE       = 32'h3F80_0000;
    localparam logic [31:0] FP_1P5       = 32'h3FC0_0000;
    localparam logic [31:0] FP_MINUS_QTR = 32'hBE80_0000;
    localparam logic [31:0] FP_BIG_NEG   = 32'hC348_0000;

    localparam longint Q24_SAT = 64'sh8000_0000;

    localparam int SETTLE_CYCLES  = 64;
    localparam int OUT_HOLD       = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic signed [15:0] mono;
        logic               pkt_end;
    } t_mono_frame;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic [31:0]          i_sample_bits = '0;
    logic                 i_silent      = 1'b0;
    logic                 i_packet_last = 1'b0;
    logic                 i_out_ready   = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic signed [15:0]   o_mono_sample;
    logic                 o_packet_end;

    logic [CFG_FMT_W-1:0] cur_format   = FMT_RESET;
    logic [CFG_CH_W-1:0]  cur_channels = CH_RESET;
    longint               acc_sum      = 0;
    int                   acc_count    = 0;
    bit                   acc_silent   = 1'b0;
    bit                   acc_pkt_end  = 1'b0;

    t_mono_frame frames_due[$];
    int          errors       = 0;
    int          quiet_cycles = 0;
    bit          offering     = 1'b0;
    bit          calm         = 1'b0;
    bit          hold_out_req = 1'b0;

    multichannel_to_mono_pcm16_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample_bits (i_sample_bits),
        .i_silent      (i_silent),
        .i_packet_last (i_packet_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_mono_sample (o_mono_sample),
        .o_packet_end  (o_packet_end)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint q24_from_float(input logic [31:0] bits);
        logic [7:0] expo;
        longint     sig;
        longint     mag;
        int         rs;
        expo = bits[30:23];
        sig  = longint'({1'b1, bits[22:0]});
        rs   = 126 - int'(expo);
        if (expo == 8'hFF) begin
            if (bits[22:0] != '0) begin
                return 0;
            end
            mag = Q24_SAT;
        end else if (expo == 8'h00) begin
            mag = 0;
        end else if (expo >= 8'd134) begin
            mag = Q24_SAT;
        end else if (expo >= 8'd126) begin
            mag = sig << (int'(expo) - 126);
        end else if (rs >= 24) begin
            mag = 0;
        end else begin
            mag = sig >> rs;
        end
        return bits[31] ? -mag : mag;
    endfunction

    function automatic void clear_frame();
        acc_sum     = 0;
        acc_count   = 0;
        acc_silent  = 1'b0;
        acc_pkt_end = 1'b0;
    endfunction

    function automatic void accumulate_sample(input logic [31:0] bits, input logic sil,
                                              input logic last);
        shortint     s16;
        longint      mag;
        longint      q;
        longint      den;
        int          ch;
        t_mono_frame f;
        s16 = bits[15:0];
        if (cur_format == FMT_INT16) begin
            acc_sum += longint'(s16);
        end else if (cur_format == FMT_FLOAT32) begin
            acc_sum += q24_from_float(bits);
        end
        acc_silent  |= sil;
        acc_pkt_end |= last;
        acc_count++;
        ch = (cur_channels == 0) ? 1 :
             (cur_channels > MAX_CHANNELS) ? MAX_CHANNELS : int'(cur_channels);
        if (acc_count < ch) begin
            return;
        end
        mag = (acc_sum < 0) ? -acc_sum : acc_sum;
        if (acc_silent) begin
            q = 0;
        end else if (cur_format == FMT_INT16) begin
            den = longint'(ch) * 32768;
            q   = (2 * mag * 32767 + den) / (2 * den);
        end else if (cur_format == FMT_FLOAT32) begin
            den = longint'(ch) << 24;
            q   = (mag >= den) ? 32767 : (2 * mag * 32767 + den) / (2 * den);
        end else begin
            q = 0;
        end
        if (q > 32767) begin
            q = (acc_sum < 0) ? 32768 : 32767;
        end
        if (acc_sum < 0) begin
            q = -q;
        end
        f.mono    = q[15:0];
        f.pkt_end = acc_pkt_end;
        frames_due.insert(frames_due.size(), f);
        clear_frame();
    endfunction

    function automatic logic [31:0] random_float();
        logic [31:0] r;
        int          pick;
        r    = $urandom;
        pick = $urandom_range(99);
        if (pick < 60) begin
            r[30:23] = 8'($urandom_range(110, 128));
        end else if (pick < 68) begin
            r[30:23] = 8'hFF;
            if (pick < 64) begin
                r[22:0] = '0;
            end
        end else if (pick < 76) begin
            r[30:23] = 8'h00;
        end else if (pick < 84) begin
            r[30:23] = 8'($urandom_range(129, 140));
        end
        return r;
    endfunction

    function automatic logic [31:0] random_int16();
        logic [31:0] r;
        int          pick;
        r    = $urandom;
        pick = $urandom_range(99);
        if (pick < 8) begin
            r[15:0] = 16'h8000;
        end else if (pick < 16) begin
            r[15:0] = 16'h7FFF;
        end
        return r;
    endfunction

    task automatic sender_stop();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic send_sample(input logic [31:0] bits, input logic sil, input logic last);
        if (!calm && $urandom_range(99) < 11) begin
            sender_stop();
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_sample_bits <= bits;
        i_silent      <= sil;
        i_packet_last <= last;
        offering = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        accumulate_sample(bits, sil, last);
    endtask

    task automatic send_random(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            send_sample((cur_format == FMT_INT16) ? random_int16() : random_float(),
                        $urandom_range(99) < 4, $urandom_range(99) < 15);
        end
    endtask

    task automatic quiesce();
        sender_stop();
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_FORMAT) begin
            cur_format = data[CFG_FMT_W-1:0];
        end else begin
            cur_channels = data[CFG_CH_W-1:0];
        end
        clear_frame();
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_FMT_W-1:0] fmt, input logic [CFG_CH_W-1:0] ch);
        quiesce();
        cfg_write(CFG_FORMAT, CFG_W'(fmt));
        cfg_write(CFG_CHANNELS, ch);
    endtask

    task automatic test_int16_limits();
        configure(FMT_INT16, 4'd2);
        send_sample(32'h0000_7FFF, 1'b0, 1'b0);
        send_sample(32'hFFFF_7FFF, 1'b0, 1'b0);
        send_sample(32'h0000_8000, 1'b0, 1'b1);
        send_sample(32'h1234_8000, 1'b0, 1'b0);
        send_sample(32'h0000_1234, 1'b1, 1'b0);
        send_sample(32'h0000_7FFF, 1'b0, 1'b1);
    endtask

    task automatic test_float_specials();
        configure(FMT_FLOAT32, 4'd1);
        send_sample(FP_POS_INF, 1'b0, 1'b0);
        send_sample(FP_NEG_INF, 1'b0, 1'b1);
        send_sample(FP_NAN, 1'b0, 1'b0);
        send_sample(FP_SUBNORMAL, 1'b0, 1'b0);
        send_sample(FP_TINY, 1'b0, 1'b0);
        send_sample(FP_1P5, 1'b0, 1'b0);
        send_sample(FP_BIG_NEG, 1'b0, 1'b1);
    endtask

    task automatic test_channel_count_limits();
        int n;
        configure(FMT_FLOAT32, 4'd0);
        send_sample(FP_ONE_HALF, 1'b0, 1'b0);
        configure(FMT_FLOAT32, 4'd15);
        for (n = 0; n < MAX_CHANNELS; n++) begin
            send_sample(FP_MINUS_QTR, 1'b0, n == 3);
        end
        // This partial frame must be dropped by the next register write.
        send_sample(FP_ONE, 1'b0, 1'b1);
        send_sample(FP_ONE, 1'b1, 1'b0);
    endtask

    task automatic test_unsupported_formats();
        configure(FMT_SPARE_LO, 4'd2);
        send_sample(FP_ONE, 1'b0, 1'b1);
        send_sample(FP_ONE, 1'b0, 1'b0);
        configure(FMT_SPARE_HI, 4'd1);
        send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic();
        int                   ph;
        int                   pick;
        logic [CFG_FMT_W-1:0] fmt;
        logic [CFG_CH_W-1:0]  ch;
        for (ph = 0; ph < 8; ph++) begin
            pick = $urandom_range(99);
            fmt  = (pick < 40) ? FMT_INT16 : (pick < 85) ? FMT_FLOAT32 :
                   (pick < 93) ? FMT_SPARE_LO : FMT_SPARE_HI;
            ch   = (ph == 0) ? 4'd1 : (ph == 1) ? 4'(MAX_CHANNELS) : (ph == 2) ? 4'd15 :
                   (ph == 3) ? 4'd0 : 4'($urandom_range(1, MAX_CHANNELS));
            configure(fmt, ch);
            calm = (ph == 4);
            send_random(150);
            calm = 1'b0;
        end
    endtask

    task automatic test_output_stall();
        configure(FMT_INT16, 4'd1);
        hold_out_req = 1'b1;
        send_random(60);
    endtask

    task automatic test_sender_pause();
        configure(FMT_FLOAT32, 4'd4);
        send_random(22);
        sender_stop();
        while (frames_due.size() != 0) @(posedge i_clk);
        send_random(22);
    endtask

    initial begin : out_side
        forever begin
            @(posedge i_clk);
            if (hold_out_req) begin
                hold_out_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (OUT_HOLD) @(posedge i_clk);
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 11);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_mono_frame due;
        if (o_out_valid && i_out_ready) begin
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %0d/%0b",
                         $time, o_mono_sample, o_packet_end);
                errors++;
            end else begin
                due = frames_due.pop_front();
                if (o_mono_sample !== due.mono) begin
                    $display("%0t: mono_sample expected %0d actual %0d",
                             $time, due.mono, o_mono_sample);
                    errors++;
                end
                if (o_packet_end !== due.pkt_end) begin
                    $display("%0t: packet_end expected %0b actual %0b",
                             $time, due.pkt_end, o_packet_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_int16_limits();
        test_float_specials();
        test_channel_count_limits();
        test_unsupported_formats();
        test_random_traffic();
        test_output_stall();
        test_sender_pause();
        quiesce();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== multichannel_to_mono_pcm16_unit.f =====
rtl/mcmono_pkg.sv
rtl/mcmono_front.sv
rtl/mcmono_fifo.sv
rtl/mcmono_back.sv
rtl/multichannel_to_mono_pcm16_unit.sv
tb/tb.sv
